// ----- rtl/longest_prefix_match_table_assert.svh -----
// ---------------------------------------------------------------------------
// Longest prefix match table assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_MATCH_TABLE_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_TABLE_ASSERT_SVH
`ifndef SYNTH
`define LPMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LPMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LPMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/lpmt_pkg.sv -----
// ---------------------------------------------------------------------------
// Longest prefix match table package
// Command and status codes, sequencer states, route entry layout, mask helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package lpmt_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned PORT_W   = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_REPLACED = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_LOOKUP   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } entry_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

  // Count leading ones by halving search over the inverted mask.
  function automatic logic [LEN_W-1:0] lead_ones(input logic [ADDR_W-1:0] mask);
    logic [ADDR_W-1:0] v;
    logic [LEN_W-1:0]  n;
    v = ~mask;
    n = '0;
    if (v[31:16] == 16'd0) begin
      n = n + 6'd16;
      v = v << 16;
    end
    if (v[31:24] == 8'd0) begin
      n = n + 6'd8;
      v = v << 8;
    end
    if (v[31:28] == 4'd0) begin
      n = n + 6'd4;
      v = v << 4;
    end
    if (v[31:30] == 2'd0) begin
      n = n + 6'd2;
      v = v << 2;
    end
    if (v[31] == 1'b0) begin
      n = n + 6'd1;
      v = v << 1;
    end
    if (v[31] == 1'b0) begin
      n = n + 6'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/longest_prefix_match_table.sv -----
// ---------------------------------------------------------------------------
// Longest prefix match table
// Bounded IPv4 route table; insert and lookup scan all filled entries with one
// shared masked compare per cycle.
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  input   | in        | in_valid_i / in_stall_o | cmd, address, route_mask,
//          |           |                         | hop_address, port_number
//  output  | out       | out_valid_o/out_stall_i | status, hit, best_hop, best_port
//
//  The length of a transaction is set by the scan of the filled entries of the
//  entry memory through its single read port, one entry per cycle.
//  Entries fill from the lowest index and are never freed, so a fill count
//  stands in for valid bits; reset clears it at once, with no clearing pass.
//  A finished result waits in the output register while the next transaction
//  is taken; a stalled output holds the sequencer in its finish step.
// ---------------------------------------------------------------------------
`default_nettype none

`include "longest_prefix_match_table_assert.svh"

module longest_prefix_match_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [lpmt_pkg::ADDR_W-1:0]   address_i,
  input  wire logic [lpmt_pkg::ADDR_W-1:0]   route_mask_i,
  input  wire logic [lpmt_pkg::ADDR_W-1:0]   hop_address_i,
  input  wire logic [lpmt_pkg::PORT_W-1:0]   port_number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [lpmt_pkg::STATUS_W-1:0]      status_o,
  output logic                               hit_o,
  output logic [lpmt_pkg::ADDR_W-1:0]        best_hop_o,
  output logic [lpmt_pkg::PORT_W-1:0]        best_port_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  lpmt_pkg::state_e state_q, state_d;

  lpmt_pkg::cmd_e                cmd_q;
  logic [lpmt_pkg::ADDR_W-1:0]   addr_q;
  logic [lpmt_pkg::ADDR_W-1:0]   mask_q;
  logic [lpmt_pkg::ADDR_W-1:0]   hop_q;
  logic [lpmt_pkg::PORT_W-1:0]   port_q;
  logic [lpmt_pkg::LEN_W-1:0]    len_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q;

  lpmt_pkg::entry_t entry_mem_q [ENTRIES];
  lpmt_pkg::entry_t rdata_q;

  logic                          best_hit_q, best_hit_d;
  logic [lpmt_pkg::LEN_W-1:0]    best_len_q;
  logic [AW-1:0]                 best_idx_q;
  logic [lpmt_pkg::ADDR_W-1:0]   best_hop_q;
  logic [lpmt_pkg::PORT_W-1:0]   best_port_q;

  logic                          out_valid_q, out_valid_d;
  lpmt_pkg::status_e             status_q, status_d;
  logic                          hit_q, hit_d;
  logic [lpmt_pkg::ADDR_W-1:0]   out_hop_q, out_hop_d;
  logic [lpmt_pkg::PORT_W-1:0]   out_port_q, out_port_d;

  logic             accept;
  logic             scan_more;
  logic             out_free;
  logic             rd_en;
  logic             finish;
  logic             cmp_match;
  logic             cmp_upd;
  logic             has_room;
  logic             is_lookup;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             cnt_inc;
  lpmt_pkg::entry_t new_entry;

  assign is_lookup = (cmd_q == lpmt_pkg::CMD_LOOKUP);
  assign scan_more = (idx_q < cnt_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign has_room  = (cnt_q < CW'(ENTRIES));

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lpmt_pkg::ST_PREP;
        end
      end
      lpmt_pkg::ST_PREP: begin
        state_d = lpmt_pkg::ST_SCAN;
      end
      lpmt_pkg::ST_SCAN: begin
        if (!scan_more && !rd_vld_q) begin
          state_d = lpmt_pkg::ST_FINISH;
        end
      end
      lpmt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = lpmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    rd_en      = 1'b0;
    finish     = 1'b0;
    case (state_q)
      lpmt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      lpmt_pkg::ST_SCAN: begin
        rd_en = scan_more;
      end
      lpmt_pkg::ST_FINISH: begin
        finish = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Shared masked compare against the entry read last cycle.
  assign cmp_match = ((addr_q ^ rdata_q.prefix) & lpmt_pkg::len_mask(rdata_q.length)) == '0;

  always_comb begin
    if (is_lookup) begin
      cmp_upd = rd_vld_q && cmp_match && (!best_hit_q || (rdata_q.length > best_len_q));
    end else begin
      cmp_upd = rd_vld_q && cmp_match && (rdata_q.length == len_q) && !best_hit_q;
    end
  end

  always_comb begin
    new_entry.prefix = addr_q & lpmt_pkg::len_mask(len_q);
    new_entry.length = len_q;
    new_entry.hop    = hop_q;
    new_entry.port   = port_q;
    wr_en   = finish && !is_lookup && (best_hit_q || has_room);
    wr_addr = best_hit_q ? best_idx_q : cnt_q[AW-1:0];
    cnt_inc = finish && !is_lookup && !best_hit_q && has_room;
  end

  always_comb begin
    cnt_d      = cnt_inc ? (cnt_q + CW'(1)) : cnt_q;
    idx_d      = idx_q;
    rd_vld_d   = rd_en;
    best_hit_d = best_hit_q;
    if (state_q == lpmt_pkg::ST_PREP) begin
      idx_d      = '0;
      best_hit_d = 1'b0;
    end else begin
      if (rd_en) begin
        idx_d = idx_q + CW'(1);
      end
      if (cmp_upd) begin
        best_hit_d = 1'b1;
      end
    end
  end

  always_comb begin
    if (is_lookup) begin
      status_d = lpmt_pkg::STATUS_LOOKUP;
    end else if (best_hit_q) begin
      status_d = lpmt_pkg::STATUS_REPLACED;
    end else if (has_room) begin
      status_d = lpmt_pkg::STATUS_INSERTED;
    end else begin
      status_d = lpmt_pkg::STATUS_FULL;
    end
    hit_d       = is_lookup && best_hit_q;
    out_hop_d   = hit_d ? best_hop_q : '0;
    out_port_d  = hit_d ? best_port_q : '0;
    out_valid_d = finish || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpmt_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      best_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      best_hit_q  <= best_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= lpmt_pkg::cmd_e'(cmd_i);
      addr_q <= address_i;
      mask_q <= route_mask_i;
      hop_q  <= hop_address_i;
      port_q <= port_number_i;
    end
    if (state_q == lpmt_pkg::ST_PREP) begin
      len_q <= lpmt_pkg::lead_ones(mask_q);
    end
    if (rd_en) begin
      rd_idx_q <= idx_q[AW-1:0];
    end
    if (cmp_upd) begin
      best_len_q  <= rdata_q.length;
      best_idx_q  <= rd_idx_q;
      best_hop_q  <= rdata_q.hop;
      best_port_q <= rdata_q.port;
    end
    if (finish) begin
      status_q   <= status_d;
      hit_q      <= hit_d;
      out_hop_q  <= out_hop_d;
      out_port_q <= out_port_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[wr_addr] <= new_entry;
    end
    if (rd_en) begin
      rdata_q <= entry_mem_q[idx_q[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign hit_o       = hit_q;
  assign best_hop_o  = out_hop_q;
  assign best_port_o = out_port_q;

  `LPMT_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(ENTRIES), "fill count overflow")
  `LPMT_ASSERT_NEXT(a_cnt_step, clk_i, rst_ni, cnt_inc, cnt_q == $past(cnt_q) + CW'(1), "fill count step")
  `LPMT_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, out_valid_o && !hit_o, best_hop_o == '0 && best_port_o == '0, "miss payload not zero")
  `LPMT_ASSERT_IMP(a_out_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == lpmt_pkg::ST_FINISH, "result without finish")

endmodule

`default_nettype wire

// ----- tb/sv/lpmt_route_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Longest prefix match table route checker
// Watches both channels, keeps its own copy of the route table, predicts one
// result per accepted transaction and compares each delivered result in order.
// ---------------------------------------------------------------------------
module lpmt_route_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          cmd_i,
  input  logic [lpmt_pkg::ADDR_W-1:0]   address_i,
  input  logic [lpmt_pkg::ADDR_W-1:0]   route_mask_i,
  input  logic [lpmt_pkg::ADDR_W-1:0]   hop_address_i,
  input  logic [lpmt_pkg::PORT_W-1:0]   port_number_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [lpmt_pkg::STATUS_W-1:0] status_i,
  input  logic                          hit_i,
  input  logic [lpmt_pkg::ADDR_W-1:0]   best_hop_i,
  input  logic [lpmt_pkg::PORT_W-1:0]   best_port_i,
  output int                            mismatch_count_o,
  output int                            pending_count_o
);

  localparam int unsigned ADDR_W = lpmt_pkg::ADDR_W;
  localparam int unsigned PORT_W = lpmt_pkg::PORT_W;

  typedef struct packed {
    lpmt_pkg::status_e status;
    logic              hit;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } route_result_t;

  logic              route_valid  [ENTRIES];
  logic [ADDR_W-1:0] route_prefix [ENTRIES];
  int                route_length [ENTRIES];
  logic [ADDR_W-1:0] route_hop    [ENTRIES];
  logic [PORT_W-1:0] route_port   [ENTRIES];
  route_result_t     awaited_results[$];
  int                mismatches = 0;

  function automatic logic [ADDR_W-1:0] length_keep(int len);
    logic [ADDR_W-1:0] keep;
    keep = '0;
    for (int b = 0; b < len; b++) keep[ADDR_W-1-b] = 1'b1;
    return keep;
  endfunction

  function automatic route_result_t predict_route_result(
    logic cmd, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] mask,
    logic [ADDR_W-1:0] hop, logic [PORT_W-1:0] port
  );
    route_result_t     res;
    int                len;
    int                same;
    int                spare;
    int                best;
    logic [ADDR_W-1:0] pfx;
    res = '0;
    res.status = lpmt_pkg::STATUS_LOOKUP;
    if (cmd == lpmt_pkg::CMD_LOOKUP) begin
      best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (route_valid[i] && ((addr ^ route_prefix[i]) & length_keep(route_length[i])) == '0
            && (best < 0 || route_length[i] > route_length[best])) begin
          best = i;
        end
      end
      if (best >= 0) begin
        res.hit  = 1'b1;
        res.hop  = route_hop[best];
        res.port = route_port[best];
      end
      return res;
    end
    len = 0;
    while (len < ADDR_W && mask[ADDR_W-1-len]) len++;
    pfx   = addr & length_keep(len);
    same  = -1;
    spare = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (route_valid[i]) begin
        if (same < 0 && route_length[i] == len && route_prefix[i] == pfx) same = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (same >= 0) begin
      route_hop[same]  = hop;
      route_port[same] = port;
      res.status = lpmt_pkg::STATUS_REPLACED;
    end else if (spare >= 0) begin
      route_valid[spare]  = 1'b1;
      route_prefix[spare] = pfx;
      route_length[spare] = len;
      route_hop[spare]    = hop;
      route_port[spare]   = port;
      res.status = lpmt_pkg::STATUS_INSERTED;
    end else begin
      res.status = lpmt_pkg::STATUS_FULL;
    end
    return res;
  endfunction

  task automatic check_field(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) route_valid[i] = 1'b0;
      awaited_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %h hit %b hop %h port %h",
                   $time, status_i, hit_i, best_hop_i, best_port_i);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", ADDR_W'(want.status), ADDR_W'(status_i));
          check_field("hit", ADDR_W'(want.hit), ADDR_W'(hit_i));
          check_field("best_hop", want.hop, best_hop_i);
          check_field("best_port", ADDR_W'(want.port), ADDR_W'(best_port_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(predict_route_result(cmd_i, address_i, route_mask_i,
                                                       hop_address_i, port_number_i));
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= awaited_results.size();
  end

endmodule

// ----- tb/sv/longest_prefix_match_table_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Longest prefix match table testbench
// Sends directed and random insert and lookup transactions with random gaps
// and output stalls; the route checker beside the block judges every result.
// ---------------------------------------------------------------------------
module longest_prefix_match_table_tb;

  localparam int unsigned ADDR_W        = lpmt_pkg::ADDR_W;
  localparam int unsigned PORT_W        = lpmt_pkg::PORT_W;
  localparam int unsigned STATUS_W      = lpmt_pkg::STATUS_W;
  localparam int unsigned ENTRIES       = 64;
  localparam int unsigned RANDOM_ITEMS  = 1430;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = ENTRIES + 16;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                cmd_i         = lpmt_pkg::CMD_INSERT;
  logic [ADDR_W-1:0]   address_i     = '0;
  logic [ADDR_W-1:0]   route_mask_i  = '0;
  logic [ADDR_W-1:0]   hop_address_i = '0;
  logic [PORT_W-1:0]   port_number_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                hit_o;
  logic [ADDR_W-1:0]   best_hop_o;
  logic [PORT_W-1:0]   best_port_o;

  int                mismatches;
  int                outstanding;
  bit                calm        = 1'b0;
  int                stall_run   = 0;
  int                cycle_count = 0;
  logic [ADDR_W-1:0] pool_prefix[$];
  int                pool_length[$];

  longest_prefix_match_table #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .address_i    (address_i),
    .route_mask_i (route_mask_i),
    .hop_address_i(hop_address_i),
    .port_number_i(port_number_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .hit_o        (hit_o),
    .best_hop_o   (best_hop_o),
    .best_port_o  (best_port_o)
  );

  lpmt_route_checker #(
    .ENTRIES(ENTRIES)
  ) i_route_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .cmd_i           (cmd_i),
    .address_i       (address_i),
    .route_mask_i    (route_mask_i),
    .hop_address_i   (hop_address_i),
    .port_number_i   (port_number_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .hit_i           (hit_o),
    .best_hop_i      (best_hop_o),
    .best_port_i     (best_port_o),
    .mismatch_count_o(mismatches),
    .pending_count_o (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_bits(int len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

  // Add stray ones below the first zero now and then; they must not count.
  function automatic logic [ADDR_W-1:0] mask_for(int len);
    logic [ADDR_W-1:0] keep;
    keep = prefix_bits(len);
    if ($urandom_range(0, 3) != 0) return keep;
    return keep | ($urandom & ~keep & ~(32'h8000_0000 >> len));
  endfunction

  always @(posedge clk_i) begin
    if (stall_run != 0 && !calm) begin
      stall_run--;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 2) == 0);
      stall_run = idle_cycles();
    end
  end

  task automatic send_item(lpmt_pkg::cmd_e cmd, logic [ADDR_W-1:0] addr,
                           logic [ADDR_W-1:0] mask, logic [ADDR_W-1:0] hop,
                           logic [PORT_W-1:0] port);
    int gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    address_i     <= addr;
    route_mask_i  <= mask;
    hop_address_i <= hop;
    port_number_i <= port;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic send_random_item();
    int                pick;
    int                len;
    int                k;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, pool_prefix.size() - 1);
    if (pick < 65) begin
      if ($urandom_range(0, 7) != 0) begin
        addr = pool_prefix[k] | ($urandom & ~prefix_bits(pool_length[k]));
      end else begin
        addr = $urandom;
      end
      send_item(lpmt_pkg::CMD_LOOKUP, addr, $urandom, $urandom, PORT_W'($urandom));
    end else if (pick < 88) begin
      len = pool_length[k];
      send_item(lpmt_pkg::CMD_INSERT, pool_prefix[k] | ($urandom & ~prefix_bits(len)),
                mask_for(len), $urandom, PORT_W'($urandom));
    end else if (pick < 98) begin
      if ($urandom_range(0, 1) == 0) begin
        len  = $urandom_range(pool_length[k], 32);
        addr = pool_prefix[k] | ($urandom & ~prefix_bits(pool_length[k]));
      end else begin
        len  = $urandom_range(1, 32);
        addr = $urandom;
      end
      pool_prefix.push_back(addr & prefix_bits(len));
      pool_length.push_back(len);
      send_item(lpmt_pkg::CMD_INSERT, addr, mask_for(len), $urandom, PORT_W'($urandom));
    end else begin
      send_item(lpmt_pkg::CMD_INSERT, $urandom, $urandom, $urandom, PORT_W'($urandom));
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(lpmt_pkg::CMD_LOOKUP, 32'h0A00_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(lpmt_pkg::CMD_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0001, 8'h01);
    send_item(lpmt_pkg::CMD_INSERT, 32'h0A01_0203, 32'hFFFF_0000, 32'hC0A8_0002, 8'h02);
    send_item(lpmt_pkg::CMD_INSERT, 32'h0A01_02FF, 32'hFFFF_FF0F, 32'hC0A8_0003, 8'h03);
    send_item(lpmt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(lpmt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'h0A01_02C8, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'h0A01_0909, 32'h1234_5678, 32'h9ABC_DEF0, 8'h5A);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'h0AC8_0000, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_INSERT, 32'h0A01_0000, 32'hFFFF_00F0, 32'h0B0B_0B0B, 8'h7E);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'h0A01_4D01, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_INSERT, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 32'h0101_0101, 8'h80);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0202_0202, 8'h40);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'hC000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(lpmt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_AAAA, 8'hA5);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(lpmt_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00);

    pool_prefix = {32'h0A00_0000, 32'h0A01_0000, 32'h0A01_0200, 32'hFFFF_FFFF,
                   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFE};
    pool_length = {8, 16, 24, 32, 1, 0, 31};

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n % 300) >= 250;
      if (n == 480 || n == 960) drain_results();
      send_random_item();
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
